// ===== hw/rtl/bounded_priority_fifo_queue_macros.svh =====
// assertion macros for the bounded priority fifo queue
// used by the top level; relies on clk and rst_n in the including module
`ifndef BOUNDED_PRIORITY_FIFO_QUEUE_MACROS_SVH
`define BOUNDED_PRIORITY_FIFO_QUEUE_MACROS_SVH
`ifndef ASSERT_OFF
`define BPFQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BPFQ_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BPFQ_ASSERT(lbl, prop, msg)
`define BPFQ_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hw/rtl/bpfq_pkg.sv =====
// shared types and constants of the bounded priority fifo queue
// no dependencies
package bpfq_pkg;

    localparam int CNT_W      = 5;
    localparam int DATA_W     = 32;
    localparam int PRIO_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_MODE = 2'd1;

    localparam logic [CNT_W-1:0] MAX_LEN_RST = 5'd16;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_WAIT,
        S_SCAN,
        S_TAIL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        [DATA_W-1:0] data;
        logic signed [PRIO_W-1:0] prio;
    } entry_t;

endpackage

// ===== hw/rtl/bpfq_store.sv =====
// entry store of the queue: one write port, one read port, registered read data
// depends on bpfq_pkg for the entry type
module bpfq_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output bpfq_pkg::entry_t  rd_entry,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  bpfq_pkg::entry_t  wr_entry
);

    bpfq_pkg::entry_t mem [DEPTH];
    bpfq_pkg::entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

// ===== hw/rtl/bounded_priority_fifo_queue.sv =====
// bounded queue of data/priority entries, fifo or ascending priority order
// depends on bpfq_pkg, bpfq_store and bounded_priority_fifo_queue_macros.svh

// Entries sit in a circular buffer in one memory with a registered read.
// A pop reads the head entry, then captures it into the result register
// while the head advances; a rejected request, a fifo push or a push into
// an empty queue goes straight to the done state; a priority push walks the
// stored entries one per cycle through the single read port, moving each
// later entry up a slot as it goes, then writes the last one at the tail.
// A new request is taken in the cycle after the previous result has entered
// the output register, even while that result still waits. The memory
// needs no clearing after reset.
`include "bounded_priority_fifo_queue_macros.svh"

module bounded_priority_fifo_queue #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] data_in,
    input  logic signed [15:0] prio_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] data_out,
    output logic signed [15:0] prio_out,
    output logic [4:0]  count,
    output logic        is_empty,
    output logic        is_full,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    localparam int CW = bpfq_pkg::CNT_W;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = ((AW > CW) ? AW : CW) + 1;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(i);
        if (s >= SW'(DEPTH))
        begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    bpfq_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]     head_reg;
    logic [CW-1:0]     fill_reg;
    logic [CW-1:0]     idx_reg;
    logic              found_reg;
    logic [CW-1:0]     max_len_reg;
    logic              prio_mode_reg;
    bpfq_pkg::entry_t  carry_reg;
    bpfq_pkg::entry_t  new_reg;
    bpfq_pkg::status_t res_status_reg;
    bpfq_pkg::entry_t  res_entry_reg;
    logic              out_valid_reg;
    bpfq_pkg::status_t out_status_reg;
    bpfq_pkg::entry_t  out_entry_reg;
    logic [CW-1:0]     out_count_reg;
    logic              out_empty_reg;
    logic              out_full_reg;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    bpfq_pkg::entry_t  rd_entry;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    bpfq_pkg::entry_t  wr_entry;

    bpfq_pkg::entry_t  in_entry;
    logic [CW-1:0]     lim;
    logic              q_full;
    logic              is_push;
    logic              use_scan;
    logic              in_fire;
    logic              out_load;
    logic              gt;
    logic [CW-1:0]     idx_inc;
    logic              scan_more;

    assign in_entry.data = data_in;
    assign in_entry.prio = prio_in;
    assign lim       = (32'(max_len_reg) < DEPTH) ? max_len_reg : CW'(DEPTH);
    assign q_full    = fill_reg >= lim;
    assign is_push   = (req_type == bpfq_pkg::REQ_PUSH);
    assign use_scan  = prio_mode_reg && (fill_reg != '0);
    assign in_fire   = in_valid && !in_stall;
    assign gt        = $signed(rd_entry.prio) > $signed(new_reg.prio);
    assign idx_inc   = idx_reg + CW'(1);
    assign scan_more = idx_inc < fill_reg;
    assign cfg_ready = 1'b1;

    bpfq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpfq_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (!is_push)
                    begin
                        state_next = (fill_reg == '0) ? bpfq_pkg::S_DONE : bpfq_pkg::S_POP_WAIT;
                    end
                    else if (!q_full && use_scan)
                    begin
                        state_next = bpfq_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = bpfq_pkg::S_DONE;
                    end
                end
            end
            bpfq_pkg::S_POP_WAIT:
            begin
                state_next = bpfq_pkg::S_DONE;
            end
            bpfq_pkg::S_SCAN:
            begin
                state_next = scan_more ? bpfq_pkg::S_SCAN : bpfq_pkg::S_TAIL;
            end
            bpfq_pkg::S_TAIL:
            begin
                state_next = bpfq_pkg::S_DONE;
            end
            bpfq_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = bpfq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bpfq_pkg::S_IDLE;
            end
        endcase
    end

    // memory controls and handshake
    always_comb
    begin
        in_stall = 1'b1;
        out_load = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = head_reg;
        wr_en    = 1'b0;
        wr_addr  = head_reg;
        wr_entry = in_entry;
        unique case (state_reg)
            bpfq_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_fire)
                begin
                    if (!is_push)
                    begin
                        rd_en = (fill_reg != '0);
                    end
                    else if (!q_full)
                    begin
                        if (use_scan)
                        begin
                            rd_en = 1'b1;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = phys(head_reg, fill_reg);
                        end
                    end
                end
            end
            bpfq_pkg::S_SCAN:
            begin
                wr_addr = phys(head_reg, idx_reg);
                if (found_reg)
                begin
                    wr_en    = 1'b1;
                    wr_entry = carry_reg;
                end
                else if (gt)
                begin
                    wr_en    = 1'b1;
                    wr_entry = new_reg;
                end
                if (scan_more)
                begin
                    rd_en   = 1'b1;
                    rd_addr = phys(head_reg, idx_inc);
                end
            end
            bpfq_pkg::S_TAIL:
            begin
                wr_en    = 1'b1;
                wr_addr  = phys(head_reg, fill_reg);
                wr_entry = found_reg ? carry_reg : new_reg;
            end
            bpfq_pkg::S_DONE:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpfq_pkg::S_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            max_len_reg   <= bpfq_pkg::MAX_LEN_RST;
            prio_mode_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    bpfq_pkg::CFG_MAX_LEN:   max_len_reg   <= cfg_data;
                    bpfq_pkg::CFG_PRIO_MODE: prio_mode_reg <= cfg_data[0];
                    default:                 max_len_reg   <= max_len_reg;
                endcase
            end
            unique case (state_reg)
                bpfq_pkg::S_IDLE:
                begin
                    if (in_fire && is_push && !q_full)
                    begin
                        if (use_scan)
                        begin
                            idx_reg   <= '0;
                            found_reg <= 1'b0;
                        end
                        else
                        begin
                            fill_reg <= fill_reg + CW'(1);
                        end
                    end
                end
                bpfq_pkg::S_POP_WAIT:
                begin
                    head_reg <= phys(head_reg, CW'(1));
                    fill_reg <= fill_reg - CW'(1);
                end
                bpfq_pkg::S_SCAN:
                begin
                    if (gt)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (scan_more)
                    begin
                        idx_reg <= idx_inc;
                    end
                end
                bpfq_pkg::S_TAIL:
                begin
                    fill_reg <= fill_reg + CW'(1);
                end
                default:
                begin
                    fill_reg <= fill_reg;
                end
            endcase
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            new_reg       <= in_entry;
            res_entry_reg <= '0;
            if (is_push)
            begin
                res_status_reg <= q_full ? bpfq_pkg::ST_FULL : bpfq_pkg::ST_OK;
            end
            else
            begin
                res_status_reg <= (fill_reg == '0) ? bpfq_pkg::ST_EMPTY : bpfq_pkg::ST_OK;
            end
        end
        if (state_reg == bpfq_pkg::S_POP_WAIT)
        begin
            res_entry_reg <= rd_entry;
        end
        if ((state_reg == bpfq_pkg::S_SCAN) && (found_reg || gt))
        begin
            carry_reg <= rd_entry;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_entry_reg  <= res_entry_reg;
            out_count_reg  <= fill_reg;
            out_empty_reg  <= (fill_reg == '0);
            out_full_reg   <= q_full;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign data_out  = out_entry_reg.data;
    assign prio_out  = out_entry_reg.prio;
    assign count     = out_count_reg;
    assign is_empty  = out_empty_reg;
    assign is_full   = out_full_reg;

    `BPFQ_ASSERT(a_fill_bound, 32'(fill_reg) <= DEPTH, "fill count above depth")
    `BPFQ_NEVER(a_scan_range, (state_reg == bpfq_pkg::S_SCAN) && (idx_reg >= fill_reg), "scan past tail")
    `BPFQ_NEVER(a_port_clash, rd_en && wr_en && (rd_addr == wr_addr), "read and write same slot")
    `BPFQ_ASSERT(a_out_source, $rose(out_valid_reg) |-> $past(state_reg == bpfq_pkg::S_DONE), "result without done")
    `BPFQ_ASSERT(a_pop_dec, (state_reg == bpfq_pkg::S_POP_WAIT) |=> (fill_reg == $past(fill_reg) - CW'(1)), "pop did not drop count")

endmodule

// ===== bench/tb_bounded_priority_fifo_queue.sv =====
// testbench of bounded_priority_fifo_queue: a directed table, then random push/pop traffic
// over several limit and order settings, results checked against a predictor or typed row
// depends on bpfq_pkg and the rtl of bounded_priority_fifo_queue
module tb_bounded_priority_fifo_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDLE_LIMIT  = 2000;
    localparam int END_SETTLE  = 40;
    localparam int MAX_GAP     = 12;

    localparam logic [bpfq_pkg::CFG_IDX_W-1:0]  CFG_SPARE_2 = 2'd2;
    localparam logic [bpfq_pkg::CFG_IDX_W-1:0]  CFG_SPARE_3 = 2'd3;
    localparam logic [bpfq_pkg::CFG_DATA_W-1:0] MODE_FIFO   = 5'd0;
    localparam logic [bpfq_pkg::CFG_DATA_W-1:0] MODE_PRIO   = 5'd1;

    typedef struct packed {
        bpfq_pkg::status_t  status;
        logic [31:0]        data;
        logic signed [15:0] prio;
        logic [4:0]         count;
        logic               empty;
        logic               full;
    } outcome_t;

    typedef enum logic {ROW_REQ, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                          kind;
        logic                               req;
        logic [31:0]                        data;
        logic signed [15:0]                 prio;
        logic [bpfq_pkg::CFG_IDX_W-1:0]     reg_idx;
        logic [bpfq_pkg::CFG_DATA_W-1:0]    reg_val;
        bit                                 typed;
        outcome_t                           want;
    } plan_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               req_type;
    logic [31:0]        data_in;
    logic signed [15:0] prio_in;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic [31:0]        data_out;
    logic signed [15:0] prio_out;
    logic [4:0]         count;
    logic               is_empty;
    logic               is_full;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [4:0]         cfg_data;

    bpfq_pkg::entry_t queue_model[$];
    logic [4:0] model_max_len;
    logic      model_prio_mode;
    outcome_t  pending_results[$];
    plan_row_t plan[$];
    outcome_t  oldest;

    int errors       = 0;
    int idle_cycles  = 0;
    int stall_left   = 0;
    int n_pushes_ok  = 0;
    int n_pops_ok    = 0;
    int n_full       = 0;
    int n_empty      = 0;
    int n_reg_writes = 0;
    bit tx_calm      = 1'b0;
    bit rx_calm      = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    bounded_priority_fifo_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .data_in   (data_in),
        .prio_in   (prio_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data_out  (data_out),
        .prio_out  (prio_out),
        .count     (count),
        .is_empty  (is_empty),
        .is_full   (is_full),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic outcome_t predict_queue(input logic req, input logic [31:0] data,
                                               input logic signed [15:0] prio);
        outcome_t res;
        int       limit;
        int       slot;
        res = '0;
        res.status = bpfq_pkg::ST_OK;
        limit = (model_max_len < QUEUE_DEPTH) ? model_max_len : QUEUE_DEPTH;
        if (req == bpfq_pkg::REQ_PUSH)
        begin
            if (queue_model.size() >= limit)
                res.status = bpfq_pkg::ST_FULL;
            else
            begin
                slot = queue_model.size();
                if (model_prio_mode)
                begin
                    for (int i = 0; i < queue_model.size(); i++)
                    begin
                        if ($signed(queue_model[i].prio) > prio)
                        begin
                            slot = i;
                            break;
                        end
                    end
                end
                queue_model.insert(slot, '{data: data, prio: prio});
            end
        end
        else if (queue_model.size() == 0)
            res.status = bpfq_pkg::ST_EMPTY;
        else
        begin
            res.data = queue_model[0].data;
            res.prio = queue_model[0].prio;
            void'(queue_model.pop_front());
        end
        res.count = 5'(queue_model.size());
        res.empty = (queue_model.size() == 0);
        res.full  = (queue_model.size() >= limit);
        return res;
    endfunction

    function automatic void plan_req(input logic req, input logic [31:0] data,
                                     input logic signed [15:0] prio);
        plan_row_t row;
        row = '{kind: ROW_REQ, req: req, data: data, prio: prio, reg_idx: bpfq_pkg::CFG_MAX_LEN,
                reg_val: '0, typed: 1'b0, want: '0};
        plan.push_back(row);
    endfunction

    function automatic void plan_typed(input logic req, input logic [31:0] data,
                                       input logic signed [15:0] prio,
                                       input bpfq_pkg::status_t st,
                                       input logic [31:0] dout, input logic signed [15:0] pout,
                                       input logic [4:0] cnt, input logic emp, input logic ful);
        plan_row_t row;
        row = '{kind: ROW_REQ, req: req, data: data, prio: prio, reg_idx: bpfq_pkg::CFG_MAX_LEN,
                reg_val: '0, typed: 1'b1, want: '0};
        row.want.status = st;
        row.want.data   = dout;
        row.want.prio   = pout;
        row.want.count  = cnt;
        row.want.empty  = emp;
        row.want.full   = ful;
        plan.push_back(row);
    endfunction

    function automatic void plan_reg(input logic [bpfq_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [bpfq_pkg::CFG_DATA_W-1:0] val);
        plan_row_t row;
        row = '{kind: ROW_REG, req: bpfq_pkg::REQ_PUSH, data: '0, prio: '0, reg_idx: idx,
                reg_val: val, typed: 1'b0, want: '0};
        plan.push_back(row);
    endfunction

    function automatic logic signed [15:0] random_prio();
        int pick;
        pick = $urandom_range(0, 3);
        case (pick)
            0: return 16'($signed($urandom_range(0, 6)) - 3);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] random_data();
        int pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0: return 32'h0;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input logic [bpfq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bpfq_pkg::CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == bpfq_pkg::CFG_MAX_LEN)
            model_max_len = val;
        else if (idx == bpfq_pkg::CFG_PRIO_MODE)
            model_prio_mode = val[0];
        n_reg_writes++;
    endtask

    task automatic drive_req(input logic req, input logic [31:0] data,
                             input logic signed [15:0] prio, input bit typed,
                             input outcome_t want);
        int unsigned gap;
        outcome_t    predicted;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        cfg_valid <= 1'b0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        data_in  <= data;
        prio_in  <= prio;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_queue(req, data, prio);
        case (predicted.status)
            bpfq_pkg::ST_FULL:  n_full++;
            bpfq_pkg::ST_EMPTY: n_empty++;
            default:
            begin
                if (req == bpfq_pkg::REQ_PUSH)
                    n_pushes_ok++;
                else
                    n_pops_ok++;
            end
        endcase
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic field_check(input string tag, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h got %h", $time, tag, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result transfer with nothing expected, status %0d count %0d",
                             $time, status, count);
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    field_check("status", 32'(oldest.status), 32'(status));
                    field_check("data_out", oldest.data, data_out);
                    field_check("prio_out", 32'(oldest.prio), 32'(prio_out));
                    field_check("count", 32'(oldest.count), 32'(count));
                    field_check("is_empty", 32'(oldest.empty), 32'(is_empty));
                    field_check("is_full", 32'(oldest.full), 32'(is_full));
                end
                stall_left = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("bounded_priority_fifo_queue regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        logic [bpfq_pkg::CFG_DATA_W-1:0] lim;
        int                              budget;
        int                              burst;
        int                              push_pct;
        logic                            req;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        req_type        = bpfq_pkg::REQ_PUSH;
        data_in         = '0;
        prio_in         = '0;
        cfg_valid       = 1'b0;
        cfg_index       = bpfq_pkg::CFG_MAX_LEN;
        cfg_data        = '0;
        model_max_len   = bpfq_pkg::MAX_LEN_RST;
        model_prio_mode = 1'b0;

        // reset values, fifo order, field extremes
        plan_typed(bpfq_pkg::REQ_POP, 32'h0, 16'sh0,
                   bpfq_pkg::ST_EMPTY, 32'h0, 16'sh0, 5'd0, 1'b1, 1'b0);
        plan_typed(bpfq_pkg::REQ_PUSH, 32'hffff_ffff, 16'sh8000,
                   bpfq_pkg::ST_OK, 32'h0, 16'sh0, 5'd1, 1'b0, 1'b0);
        plan_typed(bpfq_pkg::REQ_PUSH, 32'h0, 16'sh7fff,
                   bpfq_pkg::ST_OK, 32'h0, 16'sh0, 5'd2, 1'b0, 1'b0);
        plan_typed(bpfq_pkg::REQ_POP, 32'h0, 16'sh0,
                   bpfq_pkg::ST_OK, 32'hffff_ffff, 16'sh8000, 5'd1, 1'b0, 1'b0);
        plan_typed(bpfq_pkg::REQ_POP, 32'h0, 16'sh0,
                   bpfq_pkg::ST_OK, 32'h0, 16'sh7fff, 5'd0, 1'b1, 1'b0);
        // priority order with a tie, then refusal when full
        plan_reg(bpfq_pkg::CFG_MAX_LEN, 5'd3);
        plan_reg(bpfq_pkg::CFG_PRIO_MODE, MODE_PRIO);
        plan_req(bpfq_pkg::REQ_PUSH, 32'h0000_0011, 16'sd5);
        plan_req(bpfq_pkg::REQ_PUSH, 32'h0000_0022, -16'sd3);
        plan_req(bpfq_pkg::REQ_PUSH, 32'h0000_0033, 16'sd5);
        plan_typed(bpfq_pkg::REQ_PUSH, 32'h0000_0044, 16'sh8000,
                   bpfq_pkg::ST_FULL, 32'h0, 16'sh0, 5'd3, 1'b0, 1'b1);
        plan_req(bpfq_pkg::REQ_POP, 32'h0, 16'sh0);
        plan_req(bpfq_pkg::REQ_POP, 32'h0, 16'sh0);
        plan_req(bpfq_pkg::REQ_POP, 32'h0, 16'sh0);
        // zero limit refuses every push
        plan_reg(bpfq_pkg::CFG_MAX_LEN, 5'd0);
        plan_typed(bpfq_pkg::REQ_PUSH, 32'h1234_5678, 16'sh1,
                   bpfq_pkg::ST_FULL, 32'h0, 16'sh0, 5'd0, 1'b1, 1'b1);
        plan_typed(bpfq_pkg::REQ_POP, 32'h0, 16'sh0,
                   bpfq_pkg::ST_EMPTY, 32'h0, 16'sh0, 5'd0, 1'b1, 1'b1);
        // limit above depth, writes to unused indexes, mode change with entries held
        plan_reg(bpfq_pkg::CFG_MAX_LEN, 5'd31);
        plan_reg(CFG_SPARE_2, 5'd0);
        plan_reg(CFG_SPARE_3, 5'd2);
        plan_req(bpfq_pkg::REQ_PUSH, 32'ha5a5_a5a5, 16'sd10);
        plan_req(bpfq_pkg::REQ_PUSH, 32'h5a5a_5a5a, -16'sd10);
        plan_reg(bpfq_pkg::CFG_PRIO_MODE, 5'h1e);
        plan_req(bpfq_pkg::REQ_PUSH, 32'h0f0f_0f0f, -16'sd20);
        plan_req(bpfq_pkg::REQ_POP, 32'h0, 16'sh0);
        plan_req(bpfq_pkg::REQ_POP, 32'h0, 16'sh0);
        plan_req(bpfq_pkg::REQ_POP, 32'h0, 16'sh0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                drive_req(plan[i].req, plan[i].data, plan[i].prio, plan[i].typed, plan[i].want);
        end

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph / 2)
                0: lim = 5'd1;
                1: lim = 5'd16;
                2: lim = 5'($urandom_range(2, 8));
                3: lim = 5'd31;
                4: lim = 5'($urandom_range(1, 16));
                default: lim = 5'd0;
            endcase
            write_reg(bpfq_pkg::CFG_MAX_LEN, lim);
            write_reg(bpfq_pkg::CFG_PRIO_MODE, (ph % 2 == 1) ? MODE_PRIO : MODE_FIFO);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            budget = (lim == 0) ? 40 : 190;
            while (budget > 0)
            begin
                burst = $urandom_range(8, 40);
                case ($urandom_range(0, 2))
                    0: push_pct = 20;
                    1: push_pct = 50;
                    default: push_pct = 80;
                endcase
                for (int k = 0; k < burst && budget > 0; k++)
                begin
                    if ($urandom_range(0, 49) == 0)
                        wait_drained();
                    req = ($urandom_range(1, 100) <= push_pct) ?
                          bpfq_pkg::REQ_PUSH : bpfq_pkg::REQ_POP;
                    drive_req(req, random_data(), random_prio(), 1'b0, '0);
                    budget--;
                end
            end
        end

        wait_drained();
        repeat (END_SETTLE) @(posedge clk);
        $display("pushes stored %0d, pops served %0d, refused full %0d, refused empty %0d",
                 n_pushes_ok, n_pops_ok, n_full, n_empty);
        $display("%0d register writes: fifo and priority order, limits zero to above depth",
                 n_reg_writes);
        if (errors == 0)
            $display("bounded_priority_fifo_queue regression: pass");
        else
            $display("bounded_priority_fifo_queue regression: fail");
        $finish;
    end

endmodule
